[rtl/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP chunked body decoder package
// Shared types, character codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // Default widths of the chunk size and the running byte count.
  localparam int unsigned SizeBitsDef  = 32;
  localparam int unsigned CountBitsDef = 48;

  // Width of the byte total carried on the result stream.
  localparam int unsigned TotalW = 48;

  // Bits that one hex digit adds to the size accumulator.
  localparam int unsigned HexDigitBits = 4;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  // Input and result stream widths.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned OutUserW = 2;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_PAYLOAD = 3'd1,
    PH_SKIP    = 3'd2,
    PH_TRAILER = 3'd3,
    PH_DONE    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_CLOSED   = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       closed;
  } item_t;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        payload;
    logic [TotalW-1:0] total_written;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decodes one ASCII hex digit; ok is low for any other character.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

[rtl/http_chunked_body_decoder_top.sv]
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Decodes a chunked transfer encoded body into payload bytes and end events.
// ----------------------------------------------------------------------------
// The decoder takes one body byte, or one end-of-connection event, per item and
// sustains one item every clock cycle while the consumer does not stall it. Each
// item passes an input register, then the parser, which updates its state and
// writes at most one result into the result register. The
// parser reads the size line as hex digits, drops carriage returns and ignores
// chunk extensions, forwards the announced number of payload bytes with a
// running total, and skips the line after each chunk. An empty size line, or a
// zero size followed by one trailer line, reports the body as complete; a close
// during a chunk reports an error, and a size that would not fit in SIZE_BITS
// reports an overflow instead of wrapping. After any such end result every
// later item is accepted and dropped until reset. Input ready follows output
// ready combinationally through the two registers, so a stalled consumer stops
// intake only once both registers are full.
module http_chunked_body_decoder_top
  import hcbd_pkg::*;
#(
  parameter int unsigned SIZE_BITS  = SizeBitsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  logic                s_axis_tuser_i,  // [0] closed
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // [7:0] payload, [55:8] total_written
  output logic [OutUserW-1:0] m_axis_tuser_o   // [1:0] kind
);

  item_t   in_item;
  item_t   held_item;
  logic    step;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.data_byte = s_axis_tdata_i;
  assign in_item.closed    = s_axis_tuser_i;

  hcbd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .out_free_i (out_free),
    .step_o     (step),
    .item_o     (held_item)
  );

  hcbd_parser #(
    .SIZE_BITS  (SIZE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hcbd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (out_res)
  );

  assign m_axis_tdata_o = {out_res.total_written, out_res.payload};
  assign m_axis_tuser_o = out_res.kind;

endmodule

[rtl/hcbd_in_stage.sv]
// ----------------------------------------------------------------------------
// HTTP chunked body decoder input stage
// Registers one input item and hands it to the parser when it can advance.
// ----------------------------------------------------------------------------
module hcbd_in_stage
  import hcbd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  out_free_i,
  output logic  step_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // The held item moves on whenever the result register can take a result.
  assign step_o     = valid_q && out_free_i;
  assign in_ready_o = !valid_q || step_o;
  assign load       = in_valid_i && in_ready_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

endmodule

[rtl/hcbd_parser.sv]
// ----------------------------------------------------------------------------
// HTTP chunked body decoder parser
// Holds the decoding state and turns one item into at most one result.
// ----------------------------------------------------------------------------
module hcbd_parser
  import hcbd_pkg::*;
#(
  parameter int unsigned SIZE_BITS  = SizeBitsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t res_o
);

  phase_e                phase_q, phase_d;
  logic                  hex_stopped_q, hex_stopped_d;
  logic                  line_nonempty_q, line_nonempty_d;
  logic [SIZE_BITS-1:0]  size_accum_q, size_accum_d;
  logic [SIZE_BITS-1:0]  bytes_left_q, bytes_left_d;
  logic [COUNT_BITS-1:0] byte_total_q, byte_total_d;
  logic [SIZE_BITS-1:0]  bytes_left_dec;
  logic [TotalW-1:0]     total_view;
  hex_t                  hex;
  kind_e                 kind;
  logic [7:0]            payload;
  logic                  res_valid;

  assign hex            = hex_decode(item_i.data_byte);
  assign bytes_left_dec = bytes_left_q - 1'b1;

  always_comb begin
    phase_d         = phase_q;
    hex_stopped_d   = hex_stopped_q;
    line_nonempty_d = line_nonempty_q;
    size_accum_d    = size_accum_q;
    bytes_left_d    = bytes_left_q;
    byte_total_d    = byte_total_q;
    res_valid       = 1'b0;
    kind            = KIND_BYTE;
    payload         = 8'd0;
    if (step_i) begin
      unique case (phase_q)
        PH_SIZE: begin
          if (item_i.closed) begin
            res_valid = 1'b1;
            phase_d   = PH_DONE;
            kind      = (line_nonempty_q && size_accum_q != '0) ? KIND_CLOSED : KIND_DONE;
          end else if (item_i.data_byte == CharCr) begin
            phase_d = PH_SIZE;
          end else if (item_i.data_byte == CharLf) begin
            if (!line_nonempty_q) begin
              res_valid = 1'b1;
              phase_d   = PH_DONE;
              kind      = KIND_DONE;
            end else if (size_accum_q == '0) begin
              phase_d = PH_TRAILER;
            end else begin
              bytes_left_d = size_accum_q;
              phase_d      = PH_PAYLOAD;
            end
          end else begin
            line_nonempty_d = 1'b1;
            if (!hex_stopped_q) begin
              if (!hex.ok) begin
                hex_stopped_d = 1'b1;
              end else if (size_accum_q[SIZE_BITS-1 -: HexDigitBits] != '0) begin
                res_valid = 1'b1;
                phase_d   = PH_DONE;
                kind      = KIND_OVERFLOW;
              end else begin
                size_accum_d = {size_accum_q[SIZE_BITS-HexDigitBits-1:0], hex.val};
              end
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          if (item_i.closed) begin
            phase_d = PH_DONE;
            kind    = KIND_CLOSED;
          end else begin
            kind         = KIND_BYTE;
            payload      = item_i.data_byte;
            byte_total_d = COUNT_BITS'(byte_total_q + 1'b1);
            bytes_left_d = bytes_left_dec;
            if (bytes_left_dec == '0) begin
              phase_d = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (item_i.closed) begin
            res_valid = 1'b1;
            phase_d   = PH_DONE;
            kind      = KIND_DONE;
          end else if (item_i.data_byte == CharLf) begin
            phase_d         = PH_SIZE;
            hex_stopped_d   = 1'b0;
            line_nonempty_d = 1'b0;
            size_accum_d    = '0;
          end
        end
        PH_TRAILER: begin
          if (item_i.closed || item_i.data_byte == CharLf) begin
            res_valid = 1'b1;
            phase_d   = PH_DONE;
            kind      = KIND_DONE;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // The total shown with a result is the count after this item.
  if (COUNT_BITS >= TotalW) begin : g_total_trunc
    assign total_view = byte_total_d[TotalW-1:0];
  end else begin : g_total_ext
    assign total_view = {{(TotalW - COUNT_BITS){1'b0}}, byte_total_d};
  end

  assign res_valid_o         = res_valid;
  assign res_o.kind          = kind;
  assign res_o.payload       = payload;
  assign res_o.total_written = total_view;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_SIZE;
      hex_stopped_q   <= 1'b0;
      line_nonempty_q <= 1'b0;
      size_accum_q    <= '0;
      bytes_left_q    <= '0;
      byte_total_q    <= '0;
    end else begin
      phase_q         <= phase_d;
      hex_stopped_q   <= hex_stopped_d;
      line_nonempty_q <= line_nonempty_d;
      size_accum_q    <= size_accum_d;
      bytes_left_q    <= bytes_left_d;
      byte_total_q    <= byte_total_d;
    end
  end

  a_done_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |-> !res_valid)
    else $error("result produced after the body ended");

  a_end_to_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && kind != KIND_BYTE) |=> (phase_q == PH_DONE))
    else $error("terminal result did not end the body");

  a_total_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && kind == KIND_BYTE) |=>
      (byte_total_q == COUNT_BITS'($past(byte_total_q) + 1'b1)))
    else $error("byte total did not advance with a payload byte");

  a_payload_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (bytes_left_q != '0))
    else $error("payload phase with no bytes left");

endmodule

[rtl/hcbd_out_stage.sv]
// ----------------------------------------------------------------------------
// HTTP chunked body decoder output stage
// Result register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module hcbd_out_stage
  import hcbd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    out_free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign out_free_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule
